// ----- hw/rtl/glyph_nibble_rle_decoder_macros.svh -----
// ----------------------------------------------------------------------------
// Glyph nibble RLE decoder assertion macros
// Concurrent check wrappers used by the decoder datapath.
// ----------------------------------------------------------------------------
`ifndef GLYPH_NIBBLE_RLE_DECODER_MACROS_SVH
`define GLYPH_NIBBLE_RLE_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define GNRD_ASSERT_IMP(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |-> (b)) \
    else $error("same-cycle check failed");
`define GNRD_ASSERT_NXT(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define GNRD_ASSERT_IMP(lbl, c, r, a, b)
`define GNRD_ASSERT_NXT(lbl, c, r, a, b)
`endif

`endif

// ----- hw/rtl/gnrd_pkg.sv -----
// ----------------------------------------------------------------------------
// Glyph nibble RLE decoder package
// Field widths, phase codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package gnrd_pkg;

  localparam int NIB_W   = 4;
  localparam int PIXEL_W = 8;
  localparam int PIX_W   = 14;

  localparam logic [1:0] PH_CODE = 2'd0;
  localparam logic [1:0] PH_RUN  = 2'd1;
  localparam logic [1:0] PH_LIT  = 2'd2;

  localparam logic [NIB_W-1:0] RUN_LIMIT = 4'd8;

  typedef struct packed {
    logic accept;
    logic run_step;
  } gnrd_cmd_t;

  typedef struct packed {
    logic out_free;
    logic enter_run;
    logic run_done;
  } gnrd_sts_t;

endpackage

// ----- hw/rtl/gnrd_ctrl.sv -----
// ----------------------------------------------------------------------------
// Glyph nibble RLE decoder controller
// Sequences input acceptance and repeated-run pixel emission.
// ----------------------------------------------------------------------------
module gnrd_ctrl
  import gnrd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  gnrd_sts_t sts,
  output gnrd_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;

  assign s_tready     = (state == ST_IDLE) && sts.out_free;
  assign cmd.accept   = s_tvalid && s_tready;
  assign cmd.run_step = (state == ST_RUN) && sts.out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.accept && sts.enter_run) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cmd.run_step && sts.run_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hw/rtl/gnrd_dp.sv -----
// ----------------------------------------------------------------------------
// Glyph nibble RLE decoder datapath
// Decode state, pixel counter, count register and output word register.
// ----------------------------------------------------------------------------
`include "glyph_nibble_rle_decoder_macros.svh"

module gnrd_dp
  import gnrd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [PIX_W-1:0] cfg_wr_data,
  input  logic [NIB_W-1:0] in_nibble,
  input  logic             in_first,
  input  gnrd_cmd_t        cmd,
  output gnrd_sts_t        sts,
  input  logic             m_tready,
  output logic             m_tvalid,
  output logic [PIXEL_W-1:0] out_pixel,
  output logic [PIX_W-1:0] out_index,
  output logic             out_last
);

  logic [PIX_W-1:0] pixel_count;
  logic [1:0]       phase;
  logic [1:0]       phase_next;
  logic [NIB_W-1:0] pending;
  logic [NIB_W-1:0] pending_next;
  logic [PIX_W-1:0] produced;
  logic [PIX_W-1:0] produced_next;
  logic             finished;
  logic             finished_next;
  logic [NIB_W-1:0] run_nib;
  logic             valid;

  logic [1:0]       eff_phase;
  logic [NIB_W-1:0] eff_pend;
  logic [PIX_W-1:0] eff_prod;
  logic             eff_fin;
  logic             done_pre;
  logic [NIB_W-1:0] emit_nib;
  logic [PIX_W-1:0] base_prod;
  logic [NIB_W-1:0] base_pend;
  logic [PIX_W-1:0] prod_inc;
  logic [NIB_W-1:0] pend_dec;
  logic             is_last;
  logic             emit_acc;
  logic             load;
  logic             acc_run;

  assign eff_phase = in_first ? PH_CODE : phase;
  assign eff_pend  = in_first ? '0 : pending;
  assign eff_prod  = in_first ? '0 : produced;
  assign eff_fin   = in_first ? 1'b0 : finished;
  assign done_pre  = eff_fin || (eff_prod >= pixel_count);

  assign emit_nib  = cmd.accept ? in_nibble : run_nib;
  assign base_prod = cmd.accept ? eff_prod : produced;
  assign base_pend = cmd.accept ? eff_pend : pending;
  assign prod_inc  = base_prod + PIX_W'(1);
  assign pend_dec  = base_pend - NIB_W'(1);
  assign is_last   = (prod_inc == pixel_count);

  assign emit_acc  = !done_pre && ((eff_phase == PH_RUN) || (eff_phase == PH_LIT));
  assign load      = (cmd.accept && emit_acc) || cmd.run_step;
  assign acc_run   = !done_pre && (eff_phase == PH_RUN);

  assign sts.out_free  = !valid || m_tready;
  assign sts.enter_run = acc_run && !is_last && (pend_dec != '0);
  assign sts.run_done  = is_last || (pend_dec == '0);

  always_comb begin
    phase_next    = phase;
    pending_next  = pending;
    produced_next = produced;
    finished_next = finished;
    if (cmd.accept) begin
      phase_next    = eff_phase;
      pending_next  = eff_pend;
      produced_next = eff_prod;
      finished_next = eff_fin;
      if (done_pre) begin
        finished_next = 1'b1;
      end else begin
        unique case (eff_phase)
          PH_RUN: begin
            produced_next = prod_inc;
            finished_next = is_last;
            if (is_last || (pend_dec == '0)) begin
              phase_next   = PH_CODE;
              pending_next = '0;
            end else begin
              pending_next = pend_dec;
            end
          end
          PH_LIT: begin
            produced_next = prod_inc;
            finished_next = is_last;
            pending_next  = pend_dec;
            if (pend_dec == '0) begin
              phase_next = PH_CODE;
            end
          end
          default: begin
            if (in_nibble < RUN_LIMIT) begin
              pending_next = in_nibble + NIB_W'(1);
              phase_next   = PH_RUN;
            end else begin
              pending_next = NIB_W'(5'd16 - {1'b0, in_nibble});
              phase_next   = PH_LIT;
            end
          end
        endcase
      end
    end else if (cmd.run_step) begin
      produced_next = prod_inc;
      finished_next = is_last;
      if (is_last || (pend_dec == '0)) begin
        phase_next   = PH_CODE;
        pending_next = '0;
      end else begin
        pending_next = pend_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count <= PIX_W'(1);
      phase       <= PH_CODE;
      pending     <= '0;
      produced    <= '0;
      finished    <= 1'b0;
      valid       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        pixel_count <= cfg_wr_data;
      end
      phase    <= phase_next;
      pending  <= pending_next;
      produced <= produced_next;
      finished <= finished_next;
      if (load) begin
        valid <= 1'b1;
      end else if (m_tready) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      run_nib <= in_nibble;
    end
    if (load) begin
      out_pixel <= {emit_nib, emit_nib};
      out_index <= base_prod;
      out_last  <= is_last;
    end
  end

  assign m_tvalid = valid;

  `GNRD_ASSERT_IMP(a_run_phase, clk, rst, cmd.run_step, phase == PH_RUN)
  `GNRD_ASSERT_IMP(a_run_pending, clk, rst, cmd.run_step, pending != '0)
  `GNRD_ASSERT_IMP(a_run_slot, clk, rst, cmd.run_step, !valid || m_tready)
  `GNRD_ASSERT_NXT(a_last_done, clk, rst, load && is_last, finished && valid && out_last)

endmodule

// ----- hw/rtl/glyph_nibble_rle_decoder.sv -----
// ----------------------------------------------------------------------------
// Glyph nibble RLE decoder
// Expands a nibble run-length glyph stream into 8-bit pixels with indices.
// ----------------------------------------------------------------------------
// channel  dir  tdata fields (low bit up)          tuser / tlast
// s_*      in   [3:0] nibble, [7:4] zero           tuser: first
// m_*      out  [7:0] pixel, [21:8] pixel_index,   tlast: last
//               [23:22] zero
// cfg_*    in   [13:0] pixel_count                 write enable only
//
// A code nibble emits no pixel and a literal nibble emits one. A run value nibble of length
// n emits n pixels at one per cycle through the output register while the output is not
// stalled; input is held off while the controller steps the run.
// A stalled output word holds in place and blocks further emission.
// Synchronous reset: decode state cleared, pixel_count back to 1.
// ----------------------------------------------------------------------------
module glyph_nibble_rle_decoder
  import gnrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [3:0] nibble
  input  logic        s_tuser,   // [0] first
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] pixel, [21:8] pixel_index
  output logic        m_tlast,
  input  logic        cfg_wr_en,
  input  logic [13:0] cfg_wr_data
);

  gnrd_cmd_t          cmd;
  gnrd_sts_t          sts;
  logic [PIXEL_W-1:0] pixel;
  logic [PIX_W-1:0]   pixel_index;
  logic [3:0]         unused_hi;

  assign unused_hi = s_tdata[7:4];

  gnrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid && (unused_hi == unused_hi)),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gnrd_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_nibble   (s_tdata[NIB_W-1:0]),
    .in_first    (s_tuser),
    .cmd         (cmd),
    .sts         (sts),
    .m_tready    (m_tready),
    .m_tvalid    (m_tvalid),
    .out_pixel   (pixel),
    .out_index   (pixel_index),
    .out_last    (m_tlast)
  );

  assign m_tdata = {2'b00, pixel_index, pixel};

endmodule

// ----- test/glyph_nibble_rle_decoder_test.sv -----
// ----------------------------------------------------------------------------
// Glyph nibble RLE decoder testbench
// Streams nibble run-length glyph data into the decoder with bursty input
// and a stalling output side, predicts every decoded pixel word and compares
// pixel, index and last flag in order. Covers zero, small and maximal pixel
// counts, runs cut at the glyph end, truncated streams, noise, and a count
// lowered in the middle of a glyph.
// ----------------------------------------------------------------------------
module glyph_nibble_rle_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gnrd_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int SETTLE      = 20;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEM_TARGET = 330;

  typedef struct {
    logic [3:0] nib;
    logic       first;
  } nibble_word_t;

  typedef struct {
    logic [PIXEL_W-1:0] pixel;
    logic [PIX_W-1:0]   index;
    logic               last;
  } pixel_word_t;

  typedef enum logic [1:0] {RX_FREE, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [13:0] cfg_wr_data = '0;

  glyph_nibble_rle_decoder dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  nibble_word_t nibble_q[$];
  pixel_word_t  pixel_expect_q[$];

  // decoder shadow state
  logic [PIX_W-1:0] glyph_pixels = 14'd1;
  logic [1:0]       dec_phase = PH_CODE;
  logic [4:0]       dec_pending = '0;
  logic [PIX_W-1:0] dec_produced = '0;
  logic             dec_finished = 1'b0;

  int live_nibbles = 0;
  int nibbles_sent = 0;
  int pixels_checked = 0;
  int lasts_seen = 0;
  int count_writes = 0;
  int mismatches = 0;

  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int   hold_left = 0;

  task automatic emit_pixel(input logic [3:0] nib);
    pixel_word_t w;
    w.pixel = {nib, nib};
    w.index = dec_produced;
    w.last  = ({1'b0, dec_produced} + 15'd1) == {1'b0, glyph_pixels};
    pixel_expect_q.push_back(w);
    dec_produced = dec_produced + 14'd1;
    if (w.last) dec_finished = 1'b1;
  endtask

  task automatic decode_nibble(input logic [3:0] nib, input logic first_flag);
    if (first_flag) begin
      dec_phase    = PH_CODE;
      dec_pending  = '0;
      dec_produced = '0;
      dec_finished = 1'b0;
    end
    if (!dec_finished && dec_produced >= glyph_pixels) dec_finished = 1'b1;
    if (dec_finished) return;
    live_nibbles++;
    case (dec_phase)
      PH_RUN: begin
        for (int i = 0; i < dec_pending && !dec_finished; i++) emit_pixel(nib);
        dec_pending = '0;
        dec_phase   = PH_CODE;
      end
      PH_LIT: begin
        emit_pixel(nib);
        dec_pending = dec_pending - 5'd1;
        if (dec_pending == 0) dec_phase = PH_CODE;
      end
      default: begin
        if (nib < RUN_LIMIT) begin
          dec_pending = {1'b0, nib} + 5'd1;
          dec_phase   = PH_RUN;
        end else begin
          dec_pending = 5'd16 - {1'b0, nib};
          dec_phase   = PH_LIT;
        end
      end
    endcase
  endtask

  // sender: bursts with random gaps
  int burst_left = 8;
  int gap_left = 0;

  always @(posedge clk) begin : sender
    nibble_word_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) decode_nibble(s_tdata[3:0], s_tuser);
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (nibble_q.size() != 0) begin
          w = nibble_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {4'b0, w.nib};
          s_tuser  <= w.first;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern plus one long hold-off on request
  rx_mode_t rx_mode = RX_FREE;
  int       rx_tick = 0;

  always @(posedge clk) begin : receiver
    pixel_word_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pixel_expect_q.size() == 0) begin
          $display("%0t unexpected pixel word: pixel %02h index %0d last %0b", $time,
                   m_tdata[7:0], m_tdata[21:8], m_tlast);
          mismatches++;
        end else begin
          want = pixel_expect_q.pop_front();
          pixels_checked++;
          if (m_tlast) lasts_seen++;
          if (m_tdata[7:0] !== want.pixel) begin
            $display("%0t pixel mismatch: expected %02h, got %02h", $time,
                     want.pixel, m_tdata[7:0]);
            mismatches++;
          end
          if (m_tdata[21:8] !== want.index) begin
            $display("%0t pixel_index mismatch: expected %0d, got %0d", $time,
                     want.index, m_tdata[21:8]);
            mismatches++;
          end
          if (m_tlast !== want.last) begin
            $display("%0t last mismatch: expected %0b, got %0b", $time,
                     want.last, m_tlast);
            mismatches++;
          end
        end
      end
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = HOLD_CYCLES;
      end
      rx_tick++;
      if (rx_tick % 64 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE:   m_tready <= 1'b1;
          RX_HALF:   m_tready <= ($urandom_range(0, 1) == 1);
          RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
          default:   m_tready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t timeout: %0d pixel words still expected", $time, pixel_expect_q.size());
      $display("glyph_nibble_rle_decoder_test NOT OK");
      $finish;
    end
  end

  task automatic push_word(input logic [3:0] nib, input logic first_flag);
    nibble_word_t w;
    w.nib   = nib;
    w.first = first_flag;
    nibble_q.push_back(w);
    nibbles_sent++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (nibble_q.size() != 0 || s_tvalid || pixel_expect_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_pixel_count(input logic [13:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    glyph_pixels = value;
    count_writes++;
  endtask

  // one code nibble and its payload; cut drops one or more payload nibbles
  task automatic queue_group(input logic first_flag, input bit cut);
    logic [3:0] code;
    int         n;
    code = 4'($urandom_range(0, 15));
    push_word(code, first_flag);
    n = (code < RUN_LIMIT) ? 1 : 16 - int'(code);
    if (cut) n = $urandom_range(0, n - 1);
    repeat (n) push_word(4'($urandom_range(0, 15)), 1'b0);
  endtask

  task automatic queue_glyph(input int groups, input bit with_first, input bit broken);
    for (int g = 0; g < groups; g++) queue_group(with_first && g == 0, broken && g == groups - 1);
  endtask

  function automatic logic [13:0] pick_pixel_count();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 14'd0;
    if (r == 1) return 14'h3FFF;
    if (r == 2) return 14'd16129;
    if (r < 9) return 14'($urandom_range(1, 8));
    return 14'($urandom_range(9, 60));
  endfunction

  initial begin
    int unsigned kind;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // no first mark after reset, count still 1; trailing nibble ignored
    @(negedge clk);
    push_word(4'h0, 1'b0);
    push_word(4'hA, 1'b0);
    push_word(4'h3, 1'b0);
    wait_drained();

    // zero pixel count
    set_pixel_count(14'd0);
    push_word(4'h7, 1'b1);
    push_word(4'hF, 1'b0);
    wait_drained();

    // full run, eight literals, run cut at the glyph end, then ignored
    set_pixel_count(14'd20);
    push_word(4'h7, 1'b1);
    push_word(4'hF, 1'b0);
    push_word(4'h8, 1'b0);
    push_word(4'h0, 1'b0);
    push_word(4'h1, 1'b0);
    push_word(4'h2, 1'b0);
    push_word(4'h3, 1'b0);
    push_word(4'h4, 1'b0);
    push_word(4'h5, 1'b0);
    push_word(4'h6, 1'b0);
    push_word(4'h9, 1'b0);
    push_word(4'h7, 1'b0);
    push_word(4'hC, 1'b0);
    push_word(4'hF, 1'b0);
    wait_drained();

    // largest count, stream stops inside a literal group
    set_pixel_count(14'h3FFF);
    push_word(4'hF, 1'b1);
    push_word(4'hE, 1'b0);
    push_word(4'h5, 1'b0);
    push_word(4'hD, 1'b0);
    push_word(4'hB, 1'b0);
    push_word(4'h8, 1'b0);
    push_word(4'h3, 1'b0);
    wait_drained();

    // count dropped below what the glyph already produced
    set_pixel_count(14'd5);
    push_word(4'h2, 1'b0);
    push_word(4'h1, 1'b1);
    push_word(4'h2, 1'b0);
    wait_drained();

    // long output hold-off while the sender keeps offering run and literal groups
    set_pixel_count(14'd400);
    @(negedge clk);
    hold_req = ~hold_req;
    queue_glyph(30, 1'b1, 1'b0);
    wait_drained();

    while (nibbles_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 3) != 0) set_pixel_count(pick_pixel_count());
      @(negedge clk);
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        queue_glyph($urandom_range(1, 10), 1'b1, 1'b0);
      end else if (kind == 7) begin
        queue_glyph($urandom_range(1, 4), 1'b0, 1'b0);
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 12)) push_word(4'($urandom_range(0, 15)),
                                                 $urandom_range(0, 3) == 0);
      end else begin
        queue_glyph($urandom_range(1, 5), 1'b1, 1'b1);
      end
      wait_drained();
    end

    $display("checked %0d pixel words (%0d marked last) from %0d nibbles sent, %0d decoded",
             pixels_checked, lasts_seen, nibbles_sent, live_nibbles);
    $display("across %0d pixel_count writes, with bursty input and output back-pressure",
             count_writes);
    if (mismatches == 0 && pixel_expect_q.size() == 0) begin
      $display("glyph_nibble_rle_decoder_test OK");
    end else begin
      $display("glyph_nibble_rle_decoder_test NOT OK");
    end
    $finish;
  end

endmodule
